// ----- hdl/crp_pkg.sv -----
// Shared types and constants for the circle record parser.
package crp_pkg;

	localparam int unsigned PHASE_W = 5;

	// Head group: four coordinates, line width, line color kind
	localparam logic [PHASE_W-1:0] HEAD_LEN   = 5'd10;
	localparam logic [PHASE_W-1:0] NARROW_LEN = 5'd1;
	localparam logic [PHASE_W-1:0] WIDE_LEN   = 5'd4;
	localparam logic [PHASE_W-1:0] WIDTH_POS  = 5'd8;
	localparam logic [PHASE_W-1:0] KIND_POS   = 5'd9;
	localparam logic [PHASE_W-1:0] COORD_END  = 5'd8;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_TRUNCATED = 1'b1;

	typedef struct packed {
		logic               status;
		logic [15:0]        left_x;
		logic [15:0]        top_y;
		logic [15:0]        right_x;
		logic [15:0]        bottom_y;
		logic [7:0]         line_width;
		logic [7:0]         line_color_kind;
		logic [31:0]        line_color;
		logic [7:0]         fill_present;
		logic [7:0]         fill_color_kind;
		logic [31:0]        fill_color;
		logic [PHASE_W-1:0] bytes_used;
	} crp_result_t;

	function automatic logic [PHASE_W-1:0] color_len(input logic [7:0] kind);
		return (kind == 8'd0) ? NARROW_LEN : WIDE_LEN;
	endfunction

endpackage

// ----- hdl/circle_record_parser_unit.sv -----
// Circle record parser: byte-serial record decode with a registered result.
//
//   channel | signals                        | direction | payload
//   --------+--------------------------------+-----------+-----------------------------------
//   in      | in_valid, in_stall             | into unit | data_byte, last_byte
//   out     | out_valid, out_stall           | from unit | status, coordinates, colors, count
//
// One byte is taken per cycle unless stalled; the result register loads on the byte that
// completes or truncates a record. The decode between the state registers and the result
// register is a few byte compares and shifts. arst_n clears the parse state and the result
// valid. in_stall rises only while a held result is stalled at the output.
module circle_record_parser_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   data_byte,
	input  logic                         last_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         status,
	output logic [15:0]                  left_x,
	output logic [15:0]                  top_y,
	output logic [15:0]                  right_x,
	output logic [15:0]                  bottom_y,
	output logic [7:0]                   line_width,
	output logic [7:0]                   line_color_kind,
	output logic [31:0]                  line_color,
	output logic [7:0]                   fill_present,
	output logic [7:0]                   fill_color_kind,
	output logic [31:0]                  fill_color,
	output logic [crp_pkg::PHASE_W-1:0]  bytes_used
);
	import crp_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [15:0]        coords_q [4];
	logic [7:0]         width_q;
	logic [7:0]         line_kind_q;
	logic [31:0]        line_color_q;
	logic [7:0]         fill_flag_q;
	logic [7:0]         fill_kind_q;
	logic [31:0]        fill_color_q;

	logic               out_valid_q;
	crp_result_t        result_q;

	logic               accept;
	logic [PHASE_W-1:0] flag_pos;
	logic [PHASE_W-1:0] n;
	logic               done;
	logic               emit;
	logic               head_ok, line_ok, flag_ok, kind_ok;
	logic [15:0]        coords_nxt [4];
	logic [7:0]         width_nxt;
	logic [7:0]         line_kind_nxt;
	logic [31:0]        line_color_nxt;
	logic [7:0]         fill_flag_nxt;
	logic [7:0]         fill_kind_nxt;
	logic [31:0]        fill_color_nxt;
	crp_result_t        res;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign n        = phase_q + 5'd1;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			coords_nxt[i] = coords_q[i];
		end
		width_nxt      = width_q;
		line_kind_nxt  = line_kind_q;
		line_color_nxt = line_color_q;
		fill_flag_nxt  = fill_flag_q;
		fill_kind_nxt  = fill_kind_q;
		fill_color_nxt = fill_color_q;
		done           = 1'b0;
		flag_pos       = HEAD_LEN + color_len(line_kind_q);

		if (phase_q < COORD_END) begin
			coords_nxt[phase_q[2:1]] = {coords_q[phase_q[2:1]][7:0], data_byte};
		end else if (phase_q == WIDTH_POS) begin
			width_nxt = data_byte;
		end else if (phase_q == KIND_POS) begin
			line_kind_nxt = data_byte;
			flag_pos      = HEAD_LEN + color_len(data_byte);
		end else if (phase_q < flag_pos) begin
			line_color_nxt = {line_color_q[23:0], data_byte};
		end else if (phase_q == flag_pos) begin
			fill_flag_nxt = data_byte;
			done          = (data_byte == 8'd0);
		end else if (phase_q == flag_pos + 5'd1) begin
			fill_kind_nxt = data_byte;
		end else begin
			fill_color_nxt = {fill_color_q[23:0], data_byte};
			done           = (n == flag_pos + 5'd2 + color_len(fill_kind_q));
		end
	end

	assign emit    = done | last_byte;
	assign head_ok = done | (n >= HEAD_LEN);
	assign line_ok = done | (n >= flag_pos);
	assign flag_ok = done | (n >= flag_pos + 5'd1);
	assign kind_ok = done | (n >= flag_pos + 5'd2);

	// Report only complete groups on a truncated record
	always_comb begin
		res.status          = done ? STATUS_OK : STATUS_TRUNCATED;
		res.left_x          = head_ok ? coords_nxt[0] : 16'd0;
		res.top_y           = head_ok ? coords_nxt[1] : 16'd0;
		res.right_x         = head_ok ? coords_nxt[2] : 16'd0;
		res.bottom_y        = head_ok ? coords_nxt[3] : 16'd0;
		res.line_width      = head_ok ? width_nxt : 8'd0;
		res.line_color_kind = head_ok ? line_kind_nxt : 8'd0;
		res.line_color      = line_ok ? line_color_nxt : 32'd0;
		res.fill_present    = flag_ok ? fill_flag_nxt : 8'd0;
		res.fill_color_kind = (kind_ok && fill_flag_nxt != 8'd0) ? fill_kind_nxt : 8'd0;
		res.fill_color      = (done && fill_flag_nxt != 8'd0) ? fill_color_nxt : 32'd0;
		if (done) begin
			res.bytes_used = n;
		end else if (kind_ok) begin
			res.bytes_used = flag_pos + 5'd2;
		end else if (flag_ok) begin
			res.bytes_used = flag_pos + 5'd1;
		end else if (line_ok) begin
			res.bytes_used = flag_pos;
		end else if (head_ok) begin
			res.bytes_used = HEAD_LEN;
		end else begin
			res.bytes_used = '0;
		end
	end

	// Parse state: advance on each byte, clear after every result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				coords_q[i] <= '0;
			end
			width_q      <= '0;
			line_kind_q  <= '0;
			line_color_q <= '0;
			fill_flag_q  <= '0;
			fill_kind_q  <= '0;
			fill_color_q <= '0;
		end else if (accept) begin
			if (emit) begin
				phase_q      <= '0;
				for (int i = 0; i < 4; i++) begin
					coords_q[i] <= '0;
				end
				width_q      <= '0;
				line_kind_q  <= '0;
				line_color_q <= '0;
				fill_flag_q  <= '0;
				fill_kind_q  <= '0;
				fill_color_q <= '0;
			end else begin
				phase_q      <= n;
				for (int i = 0; i < 4; i++) begin
					coords_q[i] <= coords_nxt[i];
				end
				width_q      <= width_nxt;
				line_kind_q  <= line_kind_nxt;
				line_color_q <= line_color_nxt;
				fill_flag_q  <= fill_flag_nxt;
				fill_kind_q  <= fill_kind_nxt;
				fill_color_q <= fill_color_nxt;
			end
		end
	end

	// Result register: load on a finishing byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			result_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = result_q.status;
	assign left_x          = result_q.left_x;
	assign top_y           = result_q.top_y;
	assign right_x         = result_q.right_x;
	assign bottom_y        = result_q.bottom_y;
	assign line_width      = result_q.line_width;
	assign line_color_kind = result_q.line_color_kind;
	assign line_color      = result_q.line_color;
	assign fill_present    = result_q.fill_present;
	assign fill_color_kind = result_q.fill_color_kind;
	assign fill_color      = result_q.fill_color;
	assign bytes_used      = result_q.bytes_used;

endmodule

// ----- dv/tb_circle_record_parser_unit.sv -----
// Testbench for circle_record_parser_unit: random byte streams checked against a record predictor.
`timescale 1ns / 1ps

import crp_pkg::*;

class circle_record_board;
	crp_result_t expected_records[$];
	int errors;

	logic [4:0]  phase;
	logic [15:0] coords [4];
	logic [7:0]  width_b;
	logic [7:0]  line_kind;
	logic [31:0] line_col;
	logic [7:0]  fill_flag;
	logic [7:0]  fill_kind;
	logic [31:0] fill_col;

	function new();
		errors = 0;
		clear_record();
	endfunction

	function void clear_record();
		phase = '0;
		foreach (coords[i]) coords[i] = '0;
		width_b = '0;
		line_kind = '0;
		line_col = '0;
		fill_flag = '0;
		fill_kind = '0;
		fill_col = '0;
	endfunction

	function logic [4:0] color_span(logic [7:0] kind);
		return (kind == 8'd0) ? NARROW_LEN : WIDE_LEN;
	endfunction

	// Absorb one accepted byte; queue a record when it completes or the buffer ends.
	function void take_byte(logic [7:0] b, logic is_last);
		logic [4:0] pos;
		logic [4:0] flag_pos;
		logic [4:0] n;
		logic [4:0] used;
		bit done;
		bit head_ok;
		bit line_ok;
		bit flag_ok;
		bit kind_ok;
		crp_result_t r;
		pos = phase;
		flag_pos = HEAD_LEN + color_span(line_kind);
		done = 1'b0;
		if (pos < COORD_END) begin
			coords[pos[2:1]] = {coords[pos[2:1]][7:0], b};
		end else if (pos == WIDTH_POS) begin
			width_b = b;
		end else if (pos == KIND_POS) begin
			line_kind = b;
			flag_pos = HEAD_LEN + color_span(b);
		end else if (pos < flag_pos) begin
			line_col = {line_col[23:0], b};
		end else if (pos == flag_pos) begin
			fill_flag = b;
			done = (b == 8'd0);
		end else if (pos == flag_pos + 5'd1) begin
			fill_kind = b;
		end else begin
			fill_col = {fill_col[23:0], b};
			done = (pos + 5'd1 == flag_pos + 5'd2 + color_span(fill_kind));
		end
		n = pos + 5'd1;
		phase = n;
		if (!done && !is_last)
			return;
		head_ok = done || n >= HEAD_LEN;
		line_ok = done || n >= flag_pos;
		flag_ok = done || n >= flag_pos + 5'd1;
		kind_ok = done || n >= flag_pos + 5'd2;
		if (done)
			used = n;
		else if (kind_ok)
			used = flag_pos + 5'd2;
		else if (flag_ok)
			used = flag_pos + 5'd1;
		else if (line_ok)
			used = flag_pos;
		else if (head_ok)
			used = HEAD_LEN;
		else
			used = '0;
		r.status          = done ? STATUS_OK : STATUS_TRUNCATED;
		r.left_x          = head_ok ? coords[0] : '0;
		r.top_y           = head_ok ? coords[1] : '0;
		r.right_x         = head_ok ? coords[2] : '0;
		r.bottom_y        = head_ok ? coords[3] : '0;
		r.line_width      = head_ok ? width_b : '0;
		r.line_color_kind = head_ok ? line_kind : '0;
		r.line_color      = line_ok ? line_col : '0;
		r.fill_present    = flag_ok ? fill_flag : '0;
		r.fill_color_kind = (kind_ok && fill_flag != 8'd0) ? fill_kind : '0;
		r.fill_color      = (done && fill_flag != 8'd0) ? fill_col : '0;
		r.bytes_used      = used;
		expected_records.push_back(r);
		clear_record();
	endfunction

	function void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	function void match_result(crp_result_t got);
		crp_result_t want;
		if (expected_records.size() == 0) begin
			errors++;
			$display("%0t: unexpected record, actual status %0h bytes_used %0d",
				$time, got.status, got.bytes_used);
			return;
		end
		want = expected_records.pop_front();
		check_field("status", 32'(want.status), 32'(got.status));
		check_field("left_x", 32'(want.left_x), 32'(got.left_x));
		check_field("top_y", 32'(want.top_y), 32'(got.top_y));
		check_field("right_x", 32'(want.right_x), 32'(got.right_x));
		check_field("bottom_y", 32'(want.bottom_y), 32'(got.bottom_y));
		check_field("line_width", 32'(want.line_width), 32'(got.line_width));
		check_field("line_color_kind", 32'(want.line_color_kind),
			32'(got.line_color_kind));
		check_field("line_color", want.line_color, got.line_color);
		check_field("fill_present", 32'(want.fill_present), 32'(got.fill_present));
		check_field("fill_color_kind", 32'(want.fill_color_kind),
			32'(got.fill_color_kind));
		check_field("fill_color", want.fill_color, got.fill_color);
		check_field("bytes_used", 32'(want.bytes_used), 32'(got.bytes_used));
	endfunction

	function int pending();
		return expected_records.size();
	endfunction
endclass

module tb_circle_record_parser_unit;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int TARGET_BYTES = 1500;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           data_byte;
	logic                 last_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic                 status;
	logic [15:0]          left_x;
	logic [15:0]          top_y;
	logic [15:0]          right_x;
	logic [15:0]          bottom_y;
	logic [7:0]           line_width;
	logic [7:0]           line_color_kind;
	logic [31:0]          line_color;
	logic [7:0]           fill_present;
	logic [7:0]           fill_color_kind;
	logic [31:0]          fill_color;
	logic [PHASE_W-1:0]   bytes_used;

	circle_record_board board = new();

	int sent_bytes = 0;
	int hold_len = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit snd_burst = 1'b0;
	bit rcv_burst = 1'b0;
	bit held_once = 1'b0;
	crp_result_t got_record;

	circle_record_parser_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.left_x          (left_x),
		.top_y           (top_y),
		.right_x         (right_x),
		.bottom_y        (bottom_y),
		.line_width      (line_width),
		.line_color_kind (line_color_kind),
		.line_color      (line_color),
		.fill_present    (fill_present),
		.fill_color_kind (fill_color_kind),
		.fill_color      (fill_color),
		.bytes_used      (bytes_used)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] rand_kind();
		return $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
	endfunction

	// Offer one request after a random gap, or none in burst mode; called and returns at a falling edge.
	task automatic send_byte(input logic [7:0] d, input logic l);
		int gap;
		gap = snd_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		board.take_byte(d, l);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic random_record();
		logic [7:0] rec[$];
		logic [7:0] lk;
		logic [7:0] ff;
		logic [7:0] fk;
		int mode;
		int len;
		int noise_len;
		bit end_mark;
		repeat (9) rec.push_back(rand_byte());
		lk = rand_kind();
		rec.push_back(lk);
		repeat ((lk == 8'd0) ? 1 : 4) rec.push_back(rand_byte());
		ff = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		rec.push_back(ff);
		if (ff != 8'd0) begin
			fk = rand_kind();
			rec.push_back(fk);
			repeat ((fk == 8'd0) ? 1 : 4) rec.push_back(rand_byte());
		end
		mode = $urandom_range(0, 19);
		if (mode >= 18) begin
			// Noise; end it with a buffer mark to resync the parser
			noise_len = $urandom_range(1, 24);
			for (int i = 0; i < noise_len; i++)
				send_byte(rand_byte(), (i == noise_len - 1) || ($urandom_range(0, 5) == 0));
		end else begin
			len = (mode >= 14) ? $urandom_range(1, rec.size() - 1) : rec.size();
			end_mark = (mode >= 14) || $urandom_range(0, 1);
			for (int i = 0; i < len; i++)
				send_byte(rec[i], end_mark && (i == len - 1));
		end
	endtask

	// Sender and end of run
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Widest record, all ones, buffer mark on the completing byte
		repeat (19) send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// All zeros: narrow line color, no fill
		repeat (12) send_byte(8'h00, 1'b0);
		// Buffer ends on the first byte
		send_byte(8'h5A, 1'b1);

		while (sent_bytes < TARGET_BYTES) begin
			if ($urandom_range(0, 3) == 0)
				snd_burst = !snd_burst;
			if (!held_once && sent_bytes > TARGET_BYTES / 3) begin
				// Hold the output long enough to back up the input
				hold_len = HOLD_CYCLES;
				held_once = 1'b1;
			end
			random_record();
		end
		in_valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Receiver stall, one value per falling edge
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				hold_len--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			got_record.status          = status;
			got_record.left_x          = left_x;
			got_record.top_y           = top_y;
			got_record.right_x         = right_x;
			got_record.bottom_y        = bottom_y;
			got_record.line_width      = line_width;
			got_record.line_color_kind = line_color_kind;
			got_record.line_color      = line_color;
			got_record.fill_present    = fill_present;
			got_record.fill_color_kind = fill_color_kind;
			got_record.fill_color      = fill_color;
			got_record.bytes_used      = bytes_used;
			board.match_result(got_record);
			stall_left = rcv_burst ? 0 : $urandom_range(0, 18);
			if ($urandom_range(0, 15) == 0)
				rcv_burst = !rcv_burst;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request or record moved for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

// ----- sim.f -----
hdl/crp_pkg.sv
hdl/circle_record_parser_unit.sv
dv/tb_circle_record_parser_unit.sv
